// ===== sv/sba_pkg.sv =====
// Shared types, widths, codes and reset values of the slab block allocator.
// No dependencies; sba_ctrl, sba_dp and the top level refer to it by scoped names, the testbench imports it.

package sba_pkg;

    // Field widths
    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 17;
    localparam int CNT_W    = 11;
    localparam int STAT_W   = 3;
    localparam int PROD_W   = SIZE_W + CNT_W;

    // Used-bit RAM row organization
    localparam int WORD_BITS = 32;
    localparam int WORD_LOG  = 5;

    // Configuration port
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 64;
    localparam int CFG_IW  = 2;

    localparam logic [CFG_IW-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_SIZE  = 2'd1;
    localparam logic [CFG_IW-1:0] REG_COUNT = 2'd2;

    // Reset values
    localparam logic [ADDR_W-1:0] BASE_RST  = 48'd4096;
    localparam logic [SIZE_W-1:0] SIZE_RST  = 17'd16;
    localparam logic [CNT_W-1:0]  COUNT_RST = 11'd1024;
    localparam int                MAX_BLOCKS_DEF = 1024;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_ALLOCATED = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_FREED     = 3'd2;
    localparam logic [STAT_W-1:0] ST_OUTSIDE   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_USED  = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic              capture;
        logic              rd_scan;
        logic              scan_adv;
        logic              take_index;
        logic              mul_idx;
        logic              mul_bound;
        logic              div_init;
        logic              div_step;
        logic              rd_idx;
        logic              clr_bit;
        logic              finish;
        logic [STAT_W-1:0] code;
    } sba_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic zero_free;
        logic found;
        logic last_row;
        logic outside;
        logic div_last;
        logic bit_set;
    } sba_stat_t;

endpackage

// ===== sv/sba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module sba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sba_ctrl.sv =====
// Sequencer of the slab block allocator: walks allocate and free requests.
// Depends on sba_pkg for command and status structs and status codes.

module sba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                action,
    input  sba_pkg::sba_stat_t  stat,
    output sba_pkg::sba_cmd_t   cmd,
    output logic                busy,
    output logic                done
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_A_RD  = 4'd1;
    localparam logic [3:0] S_A_CHK = 4'd2;
    localparam logic [3:0] S_A_MUL = 4'd3;
    localparam logic [3:0] S_A_FIN = 4'd4;
    localparam logic [3:0] S_F_MUL = 4'd5;
    localparam logic [3:0] S_F_CHK = 4'd6;
    localparam logic [3:0] S_F_DIV = 4'd7;
    localparam logic [3:0] S_F_RD  = 4'd8;
    localparam logic [3:0] S_F_BIT = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       done_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = sba_pkg::ST_FULL;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = action ? S_F_MUL : S_A_RD;
                end
            end
            S_A_RD:
            begin
                if (stat.zero_free)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = sba_pkg::ST_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_A_CHK;
                end
            end
            S_A_CHK:
            begin
                if (stat.found)
                begin
                    cmd.take_index = 1'b1;
                    state_next     = S_A_MUL;
                end
                else if (stat.last_row)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = sba_pkg::ST_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                    cmd.rd_scan  = 1'b1;
                end
            end
            S_A_MUL:
            begin
                cmd.mul_idx = 1'b1;
                state_next  = S_A_FIN;
            end
            S_A_FIN:
            begin
                cmd.finish = 1'b1;
                cmd.code   = sba_pkg::ST_ALLOCATED;
                state_next = S_IDLE;
            end
            S_F_MUL:
            begin
                cmd.mul_bound = 1'b1;
                state_next    = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (stat.outside)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = sba_pkg::ST_OUTSIDE;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_F_DIV;
                end
            end
            S_F_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_F_RD;
                end
            end
            S_F_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_F_BIT;
            end
            S_F_BIT:
            begin
                cmd.finish = 1'b1;
                if (stat.bit_set)
                begin
                    cmd.clr_bit = 1'b1;
                    cmd.code    = sba_pkg::ST_FREED;
                end
                else
                begin
                    cmd.code = sba_pkg::ST_NOT_USED;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // A result strobe is never held high
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // An accepted request always leaves idle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start work");

endmodule

// ===== sv/sba_dp.sv =====
// Datapath of the slab block allocator: used-bit RAM, row scan, bound check,
// bit-serial index divider, free counter and result registers.
// Depends on sba_pkg and sba_ram.

module sba_dp #(
    parameter int MAX_BLOCKS = sba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sba_pkg::sba_cmd_t                 cmd,
    output sba_pkg::sba_stat_t                stat,
    input  logic [sba_pkg::ADDR_W-1:0]        address,
    input  logic [sba_pkg::ADDR_W-1:0]        base_address,
    input  logic [sba_pkg::SIZE_W-1:0]        block_size,
    input  logic [sba_pkg::CNT_W-1:0]         block_count,
    input  logic                              reinit,
    input  logic [sba_pkg::CNT_W-1:0]         reinit_count,
    output logic [sba_pkg::STAT_W-1:0]        status,
    output logic [sba_pkg::ADDR_W-1:0]        block_address,
    output logic [sba_pkg::CNT_W-1:0]         free_blocks
);

    localparam int ADDR_W    = sba_pkg::ADDR_W;
    localparam int SIZE_W    = sba_pkg::SIZE_W;
    localparam int CNT_W     = sba_pkg::CNT_W;
    localparam int STAT_W    = sba_pkg::STAT_W;
    localparam int PROD_W    = sba_pkg::PROD_W;
    localparam int WORD_BITS = sba_pkg::WORD_BITS;
    localparam int WORD_LOG  = sba_pkg::WORD_LOG;
    localparam int CNT_MAX   = (1 << CNT_W) - 1;
    localparam int EFF_MAX   = (MAX_BLOCKS < CNT_MAX) ? MAX_BLOCKS : CNT_MAX;
    localparam int ROWS      = (EFF_MAX + WORD_BITS - 1) / WORD_BITS;
    localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CMP_W     = CNT_W + 1;
    localparam int DC_W      = $clog2(CNT_W);
    localparam int CNT_RST_I = (int'(sba_pkg::COUNT_RST) < EFF_MAX) ?
                               int'(sba_pkg::COUNT_RST) : EFF_MAX;
    localparam logic [CNT_W-1:0] EFF_MAX_C = CNT_W'(EFF_MAX);
    localparam logic [CNT_W-1:0] CNT_RST   = CNT_W'(CNT_RST_I);

    logic [ADDR_W-1:0]    addr_reg;
    logic [RW-1:0]        scan_row_reg;
    logic [CNT_W-1:0]     blk_idx_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [ADDR_W-1:0]    diff_reg;
    logic                 borrow_reg;
    logic [PROD_W-1:0]    rem_reg;
    logic [PROD_W-1:0]    dvs_reg;
    logic [DC_W-1:0]      div_cnt_reg;
    logic                 rd_valid_reg;
    logic [ROWS-1:0]      row_valid_reg;
    logic [CNT_W-1:0]     free_cnt_reg;
    logic [STAT_W-1:0]    status_reg;
    logic [ADDR_W-1:0]    baddr_reg;
    logic [CNT_W-1:0]     free_out_reg;

    logic [SIZE_W-1:0]    size_eff;
    logic [CNT_W-1:0]     cnt_eff;
    logic [CNT_W-1:0]     reinit_eff;
    logic [CNT_W-1:0]     cnt_m1;
    logic [RW-1:0]        last_row_idx;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] in_range;
    logic [WORD_BITS-1:0] avail;
    logic [WORD_BITS-1:0] pick;
    logic [WORD_LOG-1:0]  bitpos;
    logic [CMP_W-1:0]     row_base;
    logic [RW-1:0]        idx_row;
    logic [WORD_LOG-1:0]  idx_bit;
    logic                 ram_we;
    logic [RW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [RW-1:0]        ram_raddr;
    logic [RW-1:0]        scan_rd_addr;
    logic [CNT_W-1:0]     mul_a;
    logic                 div_ge;
    logic [CNT_W-1:0]     cnt_next;

    // Effective size and count: zero size acts as one, count saturates
    assign size_eff   = (block_size == '0) ? SIZE_W'(1) : block_size;
    assign cnt_eff    = (block_count > EFF_MAX_C) ? EFF_MAX_C : block_count;
    assign reinit_eff = (reinit_count > EFF_MAX_C) ? EFF_MAX_C : reinit_count;
    assign cnt_m1       = cnt_eff - CNT_W'(1);
    assign last_row_idx = RW'(cnt_m1 >> WORD_LOG);

    // Row word as read; a row never written since reinit reads as all free
    assign rd_word = rd_valid_reg ? ram_rdata : '0;

    // Lowest free block of the current scan row, inside the slab
    assign row_base = CMP_W'({scan_row_reg, {WORD_LOG{1'b0}}});

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            in_range[j] = (row_base + CMP_W'(j)) < {1'b0, cnt_eff};
        end
    end

    assign avail = ~rd_word & in_range;
    assign pick  = avail & (~avail + WORD_BITS'(1));

    always_comb
    begin
        bitpos = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (pick[j])
            begin
                bitpos = bitpos | WORD_LOG'(j);
            end
        end
    end

    // Row and bit of the block index
    assign idx_row = RW'(blk_idx_reg >> WORD_LOG);
    assign idx_bit = blk_idx_reg[WORD_LOG-1:0];

    // RAM port control
    assign scan_rd_addr = cmd.scan_adv ? scan_row_reg + RW'(1) : scan_row_reg;
    assign ram_re    = cmd.rd_scan | cmd.rd_idx;
    assign ram_raddr = cmd.rd_idx ? idx_row : scan_rd_addr;
    assign ram_we    = cmd.take_index | cmd.clr_bit;
    assign ram_waddr = cmd.take_index ? scan_row_reg : idx_row;
    assign ram_wdata = cmd.take_index ? (rd_word | pick)
                                      : (rd_word & ~(WORD_BITS'(1) << idx_bit));

    sba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROWS),
        .AW    (RW)
    ) u_used_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Multiplier operand: found index for allocate, count for the free bound
    assign mul_a  = cmd.mul_idx ? blk_idx_reg : cnt_eff;
    assign div_ge = (rem_reg >= dvs_reg);

    // Counter after the finishing transfer
    always_comb
    begin
        case (cmd.code)
            sba_pkg::ST_ALLOCATED: cnt_next = free_cnt_reg - CNT_W'(1);
            sba_pkg::ST_FREED:     cnt_next = free_cnt_reg + CNT_W'(1);
            default:               cnt_next = free_cnt_reg;
        endcase
    end

    // Status to controller
    always_comb
    begin
        stat           = '0;
        stat.zero_free = (free_cnt_reg == '0);
        stat.found     = |avail;
        stat.last_row  = (scan_row_reg == last_row_idx);
        stat.outside   = (addr_reg == '0) || borrow_reg ||
                         (diff_reg >= ADDR_W'(prod_reg));
        stat.div_last  = (div_cnt_reg == '0);
        stat.bit_set   = rd_word[idx_bit];
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= address;
        end
        if (cmd.mul_idx || cmd.mul_bound)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(size_eff);
        end
        if (cmd.mul_bound)
        begin
            {borrow_reg, diff_reg} <= {1'b0, addr_reg} - {1'b0, base_address};
        end
        if (cmd.take_index)
        begin
            blk_idx_reg <= CNT_W'({scan_row_reg, bitpos});
        end
        else if (cmd.div_init)
        begin
            blk_idx_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            blk_idx_reg <= {blk_idx_reg[CNT_W-2:0], div_ge};
        end
        if (cmd.div_init)
        begin
            rem_reg     <= PROD_W'(diff_reg);
            dvs_reg     <= PROD_W'(size_eff) << (CNT_W - 1);
            div_cnt_reg <= DC_W'(CNT_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            dvs_reg     <= dvs_reg >> 1;
            div_cnt_reg <= div_cnt_reg - DC_W'(1);
        end
        if (ram_re)
        begin
            rd_valid_reg <= row_valid_reg[ram_raddr];
        end
        if (cmd.finish)
        begin
            status_reg   <= cmd.code;
            baddr_reg    <= (cmd.code == sba_pkg::ST_ALLOCATED) ?
                            base_address + ADDR_W'(prod_reg) : '0;
            free_out_reg <= cnt_next;
        end
    end

    // Control state: scan row, row valid bits, free counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_row_reg  <= '0;
            row_valid_reg <= '0;
            free_cnt_reg  <= CNT_RST;
        end
        else
        begin
            if (cmd.capture)
            begin
                scan_row_reg <= '0;
            end
            else if (cmd.scan_adv)
            begin
                scan_row_reg <= scan_row_reg + RW'(1);
            end
            if (reinit)
            begin
                row_valid_reg <= '0;
                free_cnt_reg  <= reinit_eff;
            end
            else
            begin
                if (ram_we)
                begin
                    row_valid_reg[ram_waddr] <= 1'b1;
                end
                if (cmd.finish)
                begin
                    free_cnt_reg <= cnt_next;
                end
            end
        end
    end

    assign status        = status_reg;
    assign block_address = baddr_reg;
    assign free_blocks   = free_out_reg;

    // Free counter never exceeds the slab's block count
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= cnt_eff)
        else $error("free counter above block count");

    // A block is only taken when the scan row has a free one
    a_take_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_index |-> stat.found)
        else $error("allocation without a free block in the row");

endmodule

// ===== sv/slab_block_allocator.sv =====
// Top level of the slab block allocator: configuration registers and port,
// controller and datapath. Depends on sba_pkg, sba_ctrl, sba_dp and sba_ram.
//
// Usage:
//   Requests enter on start/action/address and are taken when start is high
//   and busy is low. action 0 allocates the lowest free block, action 1 frees
//   the block at address. Each request gives one result: status,
//   block_address and free_blocks, shown for one cycle with done high.
//   An allocate that finds no block free ends as full without a scan; else it
//   scans the used-bit RAM row by row, 32 blocks per row, through its single
//   read port. A free ends after the bound check for an address outside the
//   slab; else it runs the index divider, one quotient bit per cycle.
//   One request is worked at a time; a new one may be taken in the cycle
//   that done shows.
//   Configuration: APB registers base_address at 0x00, block_size at 0x08,
//   block_count at 0x10, to be written only while idle; the block itself
//   does not enforce this. Writing block_count frees every block. Reset
//   gives base 4096, size 16, count 1024, all blocks free, with no clearing
//   pass. The receiver of results cannot stall.

module slab_block_allocator #(
    parameter int MAX_BLOCKS = sba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            action,
    input  logic [sba_pkg::ADDR_W-1:0]      address,
    output logic                            done,
    output logic [sba_pkg::STAT_W-1:0]      status,
    output logic [sba_pkg::ADDR_W-1:0]      block_address,
    output logic [sba_pkg::CNT_W-1:0]       free_blocks,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sba_pkg::CFG_AW-1:0]      paddr,
    input  logic [sba_pkg::CFG_DW-1:0]      pwdata,
    output logic [sba_pkg::CFG_DW-1:0]      prdata,
    output logic                            pready
);

    logic [sba_pkg::ADDR_W-1:0] base_reg;
    logic [sba_pkg::SIZE_W-1:0] size_reg;
    logic [sba_pkg::CNT_W-1:0]  count_reg;
    logic [sba_pkg::CFG_IW-1:0] reg_idx;
    logic                       wr_xfer;
    logic                       reinit;
    sba_pkg::sba_cmd_t          cmd;
    sba_pkg::sba_stat_t         stat;

    // Decode the configuration transfer
    assign pready  = 1'b1;
    assign reg_idx = paddr[sba_pkg::CFG_AW-1:sba_pkg::CFG_AW-sba_pkg::CFG_IW];
    assign wr_xfer = psel & penable & pwrite & pready;
    assign reinit  = wr_xfer && (reg_idx == sba_pkg::REG_COUNT);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= sba_pkg::BASE_RST;
            size_reg  <= sba_pkg::SIZE_RST;
            count_reg <= sba_pkg::COUNT_RST;
        end
        else if (wr_xfer)
        begin
            case (reg_idx)
                sba_pkg::REG_BASE:  base_reg  <= pwdata[sba_pkg::ADDR_W-1:0];
                sba_pkg::REG_SIZE:  size_reg  <= pwdata[sba_pkg::SIZE_W-1:0];
                sba_pkg::REG_COUNT: count_reg <= pwdata[sba_pkg::CNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            sba_pkg::REG_BASE:  prdata = sba_pkg::CFG_DW'(base_reg);
            sba_pkg::REG_SIZE:  prdata = sba_pkg::CFG_DW'(size_reg);
            sba_pkg::REG_COUNT: prdata = sba_pkg::CFG_DW'(count_reg);
            default:            prdata = '0;
        endcase
    end

    sba_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    sba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .address       (address),
        .base_address  (base_reg),
        .block_size    (size_reg),
        .block_count   (count_reg),
        .reinit        (reinit),
        .reinit_count  (pwdata[sba_pkg::CNT_W-1:0]),
        .status        (status),
        .block_address (block_address),
        .free_blocks   (free_blocks)
    );

endmodule

// ===== tb/sv/tb_slab_block_allocator.sv =====
// Self-checking testbench for slab_block_allocator: directed corner requests, then
// randomized allocate/free phases under changing APB settings, with a built-in predictor.
// Depends on sba_pkg and the slab_block_allocator RTL.

module tb_slab_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import sba_pkg::*;

    localparam int     N_BLOCKS       = MAX_BLOCKS_DEF;
    localparam int     ITEM_GOAL      = 1250;
    localparam longint TIMEOUT_CYCLES = 700_000;

    localparam logic              ACT_ALLOC = 1'b0;
    localparam logic              ACT_FREE  = 1'b1;
    localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  free;
    } slab_result_t;

    // Occupancy map predictor and queue of results still owed by the block
    class slab_tracker;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size_reg;
        logic [CNT_W-1:0]  count_reg;
        bit                used [N_BLOCKS];
        int unsigned       free_left;
        slab_result_t      pending [$];
        int                fails;
        int                tally [5];

        function new();
            base      = BASE_RST;
            size_reg  = SIZE_RST;
            count_reg = COUNT_RST;
            fails     = 0;
            foreach (tally[k]) tally[k] = 0;
            reload();
        endfunction

        function int unsigned eff_count();
            return (count_reg > N_BLOCKS) ? N_BLOCKS : count_reg;
        endfunction

        function longint unsigned eff_size();
            return (size_reg == 0) ? 1 : size_reg;
        endfunction

        // Mark every block free and load the counter
        function void reload();
            foreach (used[k]) used[k] = 1'b0;
            free_left = eff_count();
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [63:0] val);
            case (idx)
                REG_BASE:  base = val[ADDR_W-1:0];
                REG_SIZE:  size_reg = val[SIZE_W-1:0];
                REG_COUNT:
                begin
                    count_reg = val[CNT_W-1:0];
                    reload();
                end
                default: ;
            endcase
        endfunction

        // Work out the result of one accepted request and advance the map
        function void note_request(logic act, logic [ADDR_W-1:0] addr);
            int unsigned       n;
            longint unsigned   sz;
            longint unsigned   top;
            longint unsigned   idx;
            int                slot;
            slab_result_t      r;
            n        = eff_count();
            sz       = eff_size();
            slot     = -1;
            r.addr   = '0;
            r.status = ST_FULL;
            if (act == ACT_ALLOC) begin
                if (free_left != 0) begin
                    for (int i = 0; i < n; i++) begin
                        if (!used[i]) begin
                            slot = i;
                            break;
                        end
                    end
                    if (slot >= 0) begin
                        used[slot] = 1'b1;
                        free_left--;
                        top      = base;
                        top      = top + slot * sz;
                        r.addr   = top[ADDR_W-1:0];
                        r.status = ST_ALLOCATED;
                    end
                end
            end
            else begin
                top = base;
                top = top + n * sz;
                if (addr == 0 || addr < base || addr >= top) begin
                    r.status = ST_OUTSIDE;
                end
                else begin
                    idx = (addr - base) / sz;
                    if (idx >= n) begin
                        r.status = ST_OUTSIDE;
                    end
                    else if (used[idx]) begin
                        used[idx] = 1'b0;
                        free_left++;
                        r.status = ST_FREED;
                    end
                    else begin
                        r.status = ST_NOT_USED;
                    end
                end
            end
            r.free = free_left[CNT_W-1:0];
            tally[r.status]++;
            pending.push_back(r);
        endfunction

        // Compare one result transfer against the oldest expectation
        function void check_result(logic [STAT_W-1:0] st, logic [ADDR_W-1:0] ad,
                                   logic [CNT_W-1:0] fr);
            slab_result_t want;
            if (pending.size() == 0) begin
                $error("result with no request outstanding: status %0d", st);
                fails++;
                return;
            end
            want = pending.pop_front();
            if (st !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, st);
                fails++;
            end
            if (ad !== want.addr) begin
                $error("block_address: expected 0x%h, got 0x%h", want.addr, ad);
                fails++;
            end
            if (fr !== want.free) begin
                $error("free_blocks: expected %0d, got %0d", want.free, fr);
                fails++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                action;
    logic [ADDR_W-1:0]   address;
    logic                done;
    logic [STAT_W-1:0]   status;
    logic [ADDR_W-1:0]   block_address;
    logic [CNT_W-1:0]    free_blocks;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    slab_tracker sb;
    int          items_sent;
    int          settings_seen;
    int          burst_left;
    bit          pacing_on;

    slab_block_allocator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .address       (address),
        .done          (done),
        .status        (status),
        .block_address (block_address),
        .free_blocks   (free_blocks),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_CYCLES * 12);
        $error("timeout with %0d results outstanding", sb.pending.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(status, block_address, free_blocks);
    end

    function automatic logic [ADDR_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[ADDR_W-1:0];
    endfunction

    // Pick a register value, leaning toward the extremes
    function automatic logic [63:0] config_value(logic [CFG_IW-1:0] idx);
        logic [63:0] r;
        int          pick;
        r    = 64'(rand48());
        pick = $urandom_range(0, 9);
        case (idx)
            REG_BASE:
                case (pick)
                    0:       r = 64'd0;
                    1:       r = 64'd1;
                    2:       r = 64'hFFFF_FFFF_FFFF;
                    3:       r = 64'hFFFF_FFFF_FFFF - $urandom_range(0, 4096);
                    4, 5:    r = 64'($urandom_range(0, 65535));
                    default: ;
                endcase
            REG_SIZE:
                case (pick)
                    0:       r = 64'd0;
                    1:       r = 64'd1;
                    2:       r = 64'h1_FFFF;
                    3:       r = 64'd65536;
                    4, 5, 6: r = 64'($urandom_range(1, 64));
                    default: r = 64'(r[SIZE_W-1:0]);
                endcase
            default:
                case (pick)
                    0:       r = 64'd0;
                    1:       r = 64'd1;
                    2:       r = 64'd1024;
                    3:       r = 64'($urandom_range(1025, 2047));
                    4, 5, 6: r = 64'($urandom_range(2, 40));
                    default: r = 64'($urandom_range(1, 1024));
                endcase
        endcase
        return r;
    endfunction

    // One APB transfer: setup cycle, then access cycle
    task automatic apb_access(input logic wr, input logic [CFG_IW-1:0] idx,
                              input logic [63:0] data, output logic [63:0] rd);
        @(negedge clk);
        start   = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 3'b000};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rd = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Write a register, mirror it, and read it back unless it is the unmapped one
    task automatic set_reg(input logic [CFG_IW-1:0] idx, input logic [63:0] val);
        logic [63:0] rd;
        logic [63:0] want;
        apb_access(1'b1, idx, val, rd);
        sb.write_reg(idx, val);
        if (idx != REG_SPARE) begin
            want = (idx == REG_BASE) ? 64'(val[ADDR_W-1:0]) :
                   (idx == REG_SIZE) ? 64'(val[SIZE_W-1:0]) : 64'(val[CNT_W-1:0]);
            apb_access(1'b0, idx, 64'd0, rd);
            if (rd !== want) begin
                $error("prdata: expected 0x%h, got 0x%h", want, rd);
                sb.fails++;
            end
        end
    endtask

    // Hold start low until every result is in and the block is idle
    task automatic wait_drain();
        do
        begin
            @(negedge clk);
            start = 1'b0;
        end
        while (sb.pending.size() != 0 || busy !== 1'b0);
    endtask

    // Present one request, inserting a gap between bursts when pacing is on, and hold until taken
    task automatic request(input logic act, input logic [ADDR_W-1:0] addr);
        int gap;
        if (pacing_on && burst_left == 0) begin
            gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 60);
            repeat (gap)
            begin
                @(negedge clk);
                start = 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        start   = 1'b1;
        action  = act;
        address = addr;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_request(act, addr);
        items_sent++;
    endtask

    initial
    begin
        int unsigned     n;
        int unsigned     used_n;
        int unsigned     idx;
        longint unsigned sz;
        logic [63:0]     wide;
        int              pick;
        int              alloc_pct;
        int              len;
        bit              any_write;

        sb            = new();
        items_sent    = 0;
        settings_seen = 1;
        burst_left    = 0;
        pacing_on     = 1'b1;
        start         = 1'b0;
        action        = 1'b0;
        address       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rst_n         = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: null, below, above and inside the slab
        request(ACT_FREE, 48'd0);
        request(ACT_FREE, 48'd4096);
        request(ACT_FREE, 48'd4095);
        request(ACT_FREE, 48'hFFFF_FFFF_FFFF);
        request(ACT_ALLOC, rand48());
        request(ACT_ALLOC, rand48());
        request(ACT_FREE, 48'd4096 + 48'd16 + 48'd15);
        request(ACT_FREE, 48'd4096 + 48'd16 * 48'd1024);
        request(ACT_FREE, 48'd4096 + 48'd16 * 48'd1024 - 48'd1);
        request(ACT_ALLOC, rand48());
        wait_drain();
        // Unmapped register must change nothing
        set_reg(REG_SPARE, 64'h3);
        request(ACT_ALLOC, rand48());

        // Empty slab: allocate is full, free is outside
        wait_drain();
        set_reg(REG_COUNT, 64'd0);
        settings_seen++;
        request(ACT_ALLOC, rand48());
        request(ACT_FREE, 48'd4096);

        // Zero size acts as one; allocated address wraps past the top
        wait_drain();
        set_reg(REG_BASE, 64'hFFFF_FFFF_FFFE);
        set_reg(REG_SIZE, 64'd0);
        set_reg(REG_COUNT, 64'd3);
        settings_seen++;
        repeat (4) request(ACT_ALLOC, rand48());
        request(ACT_FREE, 48'hFFFF_FFFF_FFFF);
        request(ACT_FREE, 48'd0);

        // Oversized count saturates; largest block size
        wait_drain();
        set_reg(REG_BASE, 64'd1);
        set_reg(REG_SIZE, 64'h1_FFFF);
        set_reg(REG_COUNT, 64'd2047);
        settings_seen++;
        request(ACT_ALLOC, rand48());
        request(ACT_FREE, 48'd1 + 48'd1024 * 48'h1_FFFF - 48'd1);
        request(ACT_FREE, 48'd1 + 48'd1024 * 48'h1_FFFF);
        request(ACT_FREE, 48'd1);

        // Null address stays ignored even when the slab starts at zero
        wait_drain();
        set_reg(REG_BASE, 64'd0);
        settings_seen++;
        request(ACT_FREE, 48'd0);

        // Random phases, each under a fresh setting
        while (items_sent < ITEM_GOAL)
        begin
            wait_drain();
            any_write = 1'b0;
            if ($urandom_range(0, 9) < 6) begin
                set_reg(REG_BASE, config_value(REG_BASE));
                any_write = 1'b1;
            end
            if ($urandom_range(0, 9) < 6) begin
                set_reg(REG_SIZE, config_value(REG_SIZE));
                any_write = 1'b1;
            end
            if (!any_write || $urandom_range(0, 9) < 7)
                set_reg(REG_COUNT, config_value(REG_COUNT));
            if ($urandom_range(0, 9) == 0)
                set_reg(REG_SPARE, 64'(rand48()));
            settings_seen++;

            pacing_on = ($urandom_range(0, 3) != 0);
            alloc_pct = $urandom_range(25, 80);
            len       = $urandom_range(20, 90);
            repeat (len)
            begin
                // Occasionally let the block run dry mid-phase
                if ($urandom_range(0, 49) == 0)
                    wait_drain();
                if ($urandom_range(0, 99) < alloc_pct) begin
                    request(ACT_ALLOC, rand48());
                end
                else begin
                    n      = sb.eff_count();
                    sz     = sb.eff_size();
                    used_n = n - sb.free_left;
                    pick   = $urandom_range(0, 99);
                    wide   = sb.base;
                    if (pick < 55 && n > 0) begin
                        // Lowest-first allocation keeps the used blocks near index 0
                        idx  = $urandom_range(0, (used_n < n) ? used_n : n - 1);
                        wide = wide + idx * sz + $urandom_range(0, int'(sz) - 1);
                    end
                    else if (pick < 70 && n > 0) begin
                        idx  = $urandom_range(0, n - 1);
                        wide = wide + idx * sz;
                    end
                    else if (pick < 78) begin
                        wide = 64'd0;
                    end
                    else if (pick < 86) begin
                        wide = wide - $urandom_range(1, 16);
                    end
                    else if (pick < 92) begin
                        wide = wide + n * sz + $urandom_range(0, 3);
                    end
                    else begin
                        wide = 64'(rand48());
                    end
                    request(ACT_FREE, wide[ADDR_W-1:0]);
                end
            end
        end

        // Drain, then watch for stray results
        wait_drain();
        repeat (40) @(posedge clk);

        $display("Sent %0d requests under %0d register settings", items_sent, settings_seen);
        $display("  allocated %0d, full %0d, freed %0d, null/outside %0d, already free %0d",
                 sb.tally[ST_ALLOCATED], sb.tally[ST_FULL], sb.tally[ST_FREED],
                 sb.tally[ST_OUTSIDE], sb.tally[ST_NOT_USED]);
        if (sb.fails == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
